// ===== src/pol_pkg.sv =====
package pol_pkg;

	localparam int ACTION_W   = 2;
	localparam int POS_W      = 6;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;
	localparam int CAP_W      = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam int DEPTH_DEF      = 64;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int GROUP_SIZE     = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_GET    = 2'd2,
		ACT_CLEAR  = 2'd3
	} pol_action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} pol_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GATHER,
		ST_COMMIT
	} pol_state_t;

	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} pol_cell_ctl_t;

endpackage

// ===== src/pol_cell.sv =====
module pol_cell
	import pol_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int IDX_W      = 6,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  pol_cell_ctl_t         ctl,
	input  logic [IDX_W-1:0]      pos,
	input  logic [WORD_WIDTH-1:0] left,
	input  logic [WORD_WIDTH-1:0] right,
	input  logic [WORD_WIDTH-1:0] new_word,
	output logic [WORD_WIDTH-1:0] word,
	output logic [WORD_WIDTH-1:0] tap
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] word_nxt;

	always_comb begin
		word_nxt = word_q;
		if (ctl.shift_up) begin
			if (MY_IDX > pos) begin
				word_nxt = left;
			end else if (MY_IDX == pos) begin
				word_nxt = new_word;
			end
		end else if (ctl.shift_down) begin
			if (MY_IDX >= pos) begin
				word_nxt = right;
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;
	assign tap  = (MY_IDX == pos) ? word_q : '0;

endmodule

// ===== src/pol_gather.sv =====
module pol_gather
	import pol_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int GROUP      = GROUP_SIZE
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [WORD_WIDTH-1:0] taps [GROUP],
	output logic [WORD_WIDTH-1:0] merged
);

	logic [WORD_WIDTH-1:0] merged_q;
	logic [WORD_WIDTH-1:0] or_all;

	always_comb begin
		or_all = '0;
		for (int i = 0; i < GROUP; i++) begin
			or_all = or_all | taps[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			merged_q <= or_all;
		end
	end

	assign merged = merged_q;

endmodule

// ===== src/positional_ordered_list_core.sv =====
// channel   dir  tdata (low bit up)                         tuser
// s_axis    in   position[5:0], item_value                  action[1:0]
// m_axis    out  item_value_res, count[6:0]                 status[1:0]
// cfg       in   cfg_wdata: capacity_limit[6:0], cfg_we     -
//
// an item goes through accept, gather of the addressed cell through the
// registered group or-tree, then commit of the whole cell row and the result beat
// a new beat is taken the cycle after commit, so only one item is handled at a time
// commit waits while the result register still holds an untaken beat
// arst_n clears the count, the state and the result valid; capacity returns to 64
module positional_ordered_list_core
	import pol_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [((POS_W + WORD_WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,  // position, item_value
	input  logic [ACTION_W-1:0]   s_axis_tuser,  // action
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [((WORD_WIDTH + COUNT_W + 7) / 8) * 8 - 1:0] m_axis_tdata,  // item_value_res, count
	output logic [STATUS_W-1:0]   m_axis_tuser,  // status
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_wdata
);

	localparam int OUT_W   = ((WORD_WIDTH + COUNT_W + 7) / 8) * 8;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int NGROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int NTAPS   = NGROUPS * GROUP_SIZE;
	localparam int WIDE_A  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int WIDE_B  = (WIDE_A > POS_W) ? WIDE_A : POS_W;
	localparam int WIDE    = ((WIDE_B > COUNT_W) ? WIDE_B : COUNT_W) + 1;

	pol_state_t            state_q, state_nxt;
	pol_action_t           act_q;
	logic [POS_W-1:0]      pos_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [CNT_W-1:0]      cnt_q, cnt_nxt;
	logic [CAP_W-1:0]      cap_q;

	logic                  out_valid_q;
	logic [WORD_WIDTH-1:0] out_word_q;
	logic [COUNT_W-1:0]    out_count_q;
	pol_status_t           out_status_q;

	logic                  accept;
	logic                  gather_load;
	logic                  commit;

	logic [WIDE-1:0]       cnt_w, pos_w, cap_w, ecap_w, ins_pos_w, cnt_nxt_w;
	logic                  is_full, out_range;
	pol_status_t           status;
	logic [WORD_WIDTH-1:0] result;
	logic [WORD_WIDTH-1:0] rd_word;
	logic [IDX_W-1:0]      pos_bus;
	pol_cell_ctl_t         cell_ctl;

	logic [WORD_WIDTH-1:0] words [DEPTH];
	logic [WORD_WIDTH-1:0] taps  [NTAPS];
	logic [WORD_WIDTH-1:0] merged [NGROUPS];

	// state machine

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		gather_load   = 1'b0;
		commit        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_nxt = ST_GATHER;
				end
			end
			ST_GATHER: begin
				gather_load = 1'b1;
				state_nxt   = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					commit    = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= pol_action_t'(s_axis_tuser);
			pos_q  <= s_axis_tdata[POS_W-1:0];
			word_q <= s_axis_tdata[POS_W +: WORD_WIDTH];
		end
	end

	// capacity register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// action decode

	always_comb begin
		cnt_w     = WIDE'(cnt_q);
		pos_w     = WIDE'(pos_q);
		cap_w     = WIDE'(cap_q);
		ecap_w    = (cap_w > WIDE'(DEPTH)) ? WIDE'(DEPTH) : cap_w;
		ins_pos_w = (pos_w > cnt_w) ? cnt_w : pos_w;
		is_full   = cnt_w >= ecap_w;
		out_range = pos_w >= cnt_w;

		status   = STATUS_OK;
		result   = '0;
		cnt_nxt  = cnt_q;
		cell_ctl = '0;
		unique case (act_q)
			ACT_INSERT: begin
				if (is_full) begin
					status = STATUS_FULL;
				end else begin
					cell_ctl.shift_up = commit;
					cnt_nxt           = CNT_W'(cnt_w + WIDE'(1));
				end
			end
			ACT_DELETE: begin
				if (out_range) begin
					status = STATUS_RANGE;
				end else begin
					result              = rd_word;
					cell_ctl.shift_down = commit;
					cnt_nxt             = CNT_W'(cnt_w - WIDE'(1));
				end
			end
			ACT_GET: begin
				if (out_range) begin
					status = STATUS_RANGE;
				end else begin
					result = rd_word;
				end
			end
			ACT_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				cnt_nxt = cnt_q;
			end
		endcase
		cnt_nxt_w = WIDE'(cnt_nxt);
		pos_bus   = (act_q == ACT_INSERT) ? ins_pos_w[IDX_W-1:0] : pos_w[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (commit) begin
			cnt_q <= cnt_nxt;
		end
	end

	// cell row

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = word_q;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		pol_cell #(
			.WORD_WIDTH (WORD_WIDTH),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.pos      (pos_bus),
			.left     (left_w),
			.right    (right_w),
			.new_word (word_q),
			.word     (words[i]),
			.tap      (taps[i])
		);
	end

	for (genvar i = DEPTH; i < NTAPS; i++) begin : g_pad
		assign taps[i] = '0;
	end

	// read gather

	for (genvar g = 0; g < NGROUPS; g++) begin : g_group
		logic [WORD_WIDTH-1:0] group_taps [GROUP_SIZE];

		for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_tap
			assign group_taps[k] = taps[g*GROUP_SIZE + k];
		end

		pol_gather #(
			.WORD_WIDTH (WORD_WIDTH),
			.GROUP      (GROUP_SIZE)
		) u_gather (
			.clk    (clk),
			.load   (gather_load),
			.taps   (group_taps),
			.merged (merged[g])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			rd_word = rd_word | merged[g];
		end
	end

	// result register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_word_q   <= result;
			out_count_q  <= cnt_nxt_w[COUNT_W-1:0];
			out_status_q <= status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_count_q, out_word_q});
	assign m_axis_tuser  = out_status_q;

endmodule
